@@ hdl/lca_pkg.sv @@
package lca_pkg;

	localparam int NODE_W = 11;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;

	localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_UNBUILT = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [NODE_W-1:0] node;
		logic [NODE_W-1:0] parent_node;
		logic [NODE_W-1:0] other_node;
	} req_item_t;

	typedef struct packed {
		logic [NODE_W-1:0] ancestor;
		logic [STAT_W-1:0] status;
	} rsp_item_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CLIP_RD,
		S_CLIP_WR,
		S_LVL_RD1,
		S_LVL_RD2,
		S_LVL_WR,
		S_DEP_INIT,
		S_DEP_RD,
		S_DEP_STEP,
		S_DEP_WR,
		S_Q_SWAP,
		S_UP_RD,
		S_UP_STEP,
		S_CHK,
		S_JL_RD,
		S_JL_STEP,
		S_PAR_RD,
		S_PAR_GET,
		S_FINISH
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_SET,
		OP_BUILD,
		OP_QUERY,
		OP_CLIP_RD,
		OP_CLIP_WR,
		OP_LVL_RD1,
		OP_LVL_RD2,
		OP_LVL_WR,
		OP_DEP_INIT,
		OP_DEP_RD,
		OP_DEP_STEP,
		OP_DEP_WR,
		OP_Q_SWAP,
		OP_UP_RD,
		OP_UP_STEP,
		OP_CHK,
		OP_JL_RD,
		OP_JL_STEP,
		OP_PAR_RD,
		OP_PAR_GET,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		logic i_last;
		logic lvl_zero;
		logic lvl_last;
		logic single_level;
		logic n_zero;
		logic same;
		logic q_err;
		logic out_free;
	} dp_status_t;

endpackage

@@ hdl/lca_ram.sv @@
module lca_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

@@ hdl/lca_ctrl.sv @@
module lca_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic [lca_pkg::CMD_W-1:0]  req_cmd,
	input  lca_pkg::dp_status_t        st,
	output logic                       req_stall,
	output lca_pkg::dp_op_t            op
);

	lca_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lca_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		op        = lca_pkg::OP_NONE;
		req_stall = 1'b1;
		unique case (state_q)
			lca_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					case (req_cmd)
						lca_pkg::CMD_SET: begin
							op = lca_pkg::OP_SET;
						end
						lca_pkg::CMD_BUILD: begin
							op      = lca_pkg::OP_BUILD;
							state_d = lca_pkg::S_CLIP_RD;
						end
						lca_pkg::CMD_QUERY: begin
							op      = lca_pkg::OP_QUERY;
							state_d = st.q_err ? lca_pkg::S_FINISH : lca_pkg::S_Q_SWAP;
						end
						default: ;
					endcase
				end
			end
			lca_pkg::S_CLIP_RD: begin
				op      = lca_pkg::OP_CLIP_RD;
				state_d = lca_pkg::S_CLIP_WR;
			end
			lca_pkg::S_CLIP_WR: begin
				op = lca_pkg::OP_CLIP_WR;
				if (!st.i_last) begin
					state_d = lca_pkg::S_CLIP_RD;
				end else if (st.single_level) begin
					state_d = lca_pkg::S_DEP_INIT;
				end else begin
					state_d = lca_pkg::S_LVL_RD1;
				end
			end
			lca_pkg::S_LVL_RD1: begin
				op      = lca_pkg::OP_LVL_RD1;
				state_d = lca_pkg::S_LVL_RD2;
			end
			lca_pkg::S_LVL_RD2: begin
				op      = lca_pkg::OP_LVL_RD2;
				state_d = lca_pkg::S_LVL_WR;
			end
			lca_pkg::S_LVL_WR: begin
				op      = lca_pkg::OP_LVL_WR;
				state_d = (st.i_last && st.lvl_last) ? lca_pkg::S_DEP_INIT
					: lca_pkg::S_LVL_RD1;
			end
			lca_pkg::S_DEP_INIT: begin
				op      = lca_pkg::OP_DEP_INIT;
				state_d = st.n_zero ? lca_pkg::S_IDLE : lca_pkg::S_DEP_RD;
			end
			lca_pkg::S_DEP_RD: begin
				op      = lca_pkg::OP_DEP_RD;
				state_d = lca_pkg::S_DEP_STEP;
			end
			lca_pkg::S_DEP_STEP: begin
				op      = lca_pkg::OP_DEP_STEP;
				state_d = st.lvl_zero ? lca_pkg::S_DEP_WR : lca_pkg::S_DEP_RD;
			end
			lca_pkg::S_DEP_WR: begin
				op      = lca_pkg::OP_DEP_WR;
				state_d = st.i_last ? lca_pkg::S_IDLE : lca_pkg::S_DEP_RD;
			end
			lca_pkg::S_Q_SWAP: begin
				op      = lca_pkg::OP_Q_SWAP;
				state_d = lca_pkg::S_UP_RD;
			end
			lca_pkg::S_UP_RD: begin
				op      = lca_pkg::OP_UP_RD;
				state_d = lca_pkg::S_UP_STEP;
			end
			lca_pkg::S_UP_STEP: begin
				op      = lca_pkg::OP_UP_STEP;
				state_d = st.lvl_zero ? lca_pkg::S_CHK : lca_pkg::S_UP_RD;
			end
			lca_pkg::S_CHK: begin
				op      = lca_pkg::OP_CHK;
				state_d = st.same ? lca_pkg::S_FINISH : lca_pkg::S_JL_RD;
			end
			lca_pkg::S_JL_RD: begin
				op      = lca_pkg::OP_JL_RD;
				state_d = lca_pkg::S_JL_STEP;
			end
			lca_pkg::S_JL_STEP: begin
				op      = lca_pkg::OP_JL_STEP;
				state_d = st.lvl_zero ? lca_pkg::S_PAR_RD : lca_pkg::S_JL_RD;
			end
			lca_pkg::S_PAR_RD: begin
				op      = lca_pkg::OP_PAR_RD;
				state_d = lca_pkg::S_PAR_GET;
			end
			lca_pkg::S_PAR_GET: begin
				op      = lca_pkg::OP_PAR_GET;
				state_d = lca_pkg::S_FINISH;
			end
			lca_pkg::S_FINISH: begin
				op = lca_pkg::OP_FINISH;
				if (st.out_free) begin
					state_d = lca_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lca_pkg::S_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/lca_dp.sv @@
module lca_dp #(
	parameter int MAX_NODES   = 1024,
	parameter int LIFT_LEVELS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lca_pkg::dp_op_t               op,
	input  lca_pkg::req_item_t            req,
	input  logic                          cfg_we,
	input  logic [lca_pkg::NODE_W-1:0]    cfg_data,
	input  logic                          rsp_stall,
	output lca_pkg::dp_status_t           st,
	output logic                          rsp_valid,
	output lca_pkg::rsp_item_t            rsp
);

	localparam int NW        = lca_pkg::NODE_W;
	localparam int AW        = $clog2(MAX_NODES + 1);
	localparam int LW        = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
	localparam int DW        = LIFT_LEVELS;
	localparam int ANC_DEPTH = LIFT_LEVELS << AW;
	localparam int ARW       = $clog2(ANC_DEPTH);
	localparam int DEP_DEPTH = MAX_NODES + 1;
	localparam int DRW       = $clog2(DEP_DEPTH);

	logic [NW-1:0] node_count_q;
	logic          built_q;
	logic [NW-1:0] n_eff;
	logic [NW-1:0] i_q;
	logic [LW-1:0] lvl_q;
	logic [NW-1:0] a_q, b_q, u_q;
	logic [DW-1:0] d_q, diff_q;
	lca_pkg::rsp_item_t res_q;
	lca_pkg::rsp_item_t rsp_q;
	logic          rsp_valid_q;

	logic           anc_we;
	logic [ARW-1:0] anc_wa, anc_ra, anc_rb;
	logic [NW-1:0]  anc_wd, anc_qa, anc_qb;
	logic           dep_we;
	logic [DRW-1:0] dep_wa, dep_ra, dep_rb;
	logic [DW-1:0]  dep_wd, dep_qa, dep_qb;

	logic q_bad, set_ok, par_ok, out_free;

	function automatic logic [ARW-1:0] anc_addr(input logic [LW-1:0] lvl,
		input logic [NW-1:0] nd);
		return ARW'({lvl, AW'(nd)});
	endfunction

	assign n_eff = (32'(node_count_q) > MAX_NODES) ? NW'(MAX_NODES) : node_count_q;

	assign q_bad  = (req.node == '0) || (req.node > n_eff)
		|| (req.other_node == '0) || (req.other_node > n_eff);
	assign set_ok = (req.node >= NW'(2)) && (req.node <= n_eff);
	assign par_ok = (req.parent_node != '0) && (req.parent_node <= n_eff);

	assign out_free = !rsp_valid_q || !rsp_stall;

	assign st.i_last       = (i_q == n_eff);
	assign st.lvl_zero     = (lvl_q == '0);
	assign st.lvl_last     = (lvl_q == LW'(LIFT_LEVELS - 1));
	assign st.single_level = (LIFT_LEVELS == 1);
	assign st.n_zero       = (n_eff == '0);
	assign st.same         = (a_q == b_q);
	assign st.q_err        = q_bad || !built_q;
	assign st.out_free     = out_free;

	always_comb begin
		anc_we = 1'b0;
		anc_wa = '0;
		anc_wd = '0;
		anc_ra = '0;
		anc_rb = '0;
		dep_we = 1'b0;
		dep_wa = '0;
		dep_wd = '0;
		dep_ra = '0;
		dep_rb = '0;
		case (op)
			lca_pkg::OP_SET: begin
				anc_we = set_ok;
				anc_wa = anc_addr('0, req.node);
				anc_wd = par_ok ? req.parent_node : '0;
			end
			lca_pkg::OP_QUERY: begin
				dep_ra = DRW'(req.node);
				dep_rb = DRW'(req.other_node);
			end
			lca_pkg::OP_CLIP_RD: begin
				anc_ra = anc_addr('0, i_q);
			end
			lca_pkg::OP_CLIP_WR: begin
				anc_we = 1'b1;
				anc_wa = anc_addr('0, i_q);
				anc_wd = (i_q <= NW'(1) || anc_qa > n_eff) ? '0 : anc_qa;
			end
			lca_pkg::OP_LVL_RD1: begin
				anc_ra = anc_addr(lvl_q - LW'(1), i_q);
			end
			lca_pkg::OP_LVL_RD2: begin
				anc_ra = anc_addr(lvl_q - LW'(1), anc_qa);
			end
			lca_pkg::OP_LVL_WR: begin
				anc_we = 1'b1;
				anc_wa = anc_addr(lvl_q, i_q);
				anc_wd = anc_qa;
			end
			lca_pkg::OP_DEP_RD: begin
				anc_ra = anc_addr(lvl_q, u_q);
			end
			lca_pkg::OP_DEP_WR: begin
				dep_we = 1'b1;
				dep_wa = DRW'(i_q);
				dep_wd = d_q;
			end
			lca_pkg::OP_UP_RD: begin
				anc_ra = anc_addr(lvl_q, b_q);
			end
			lca_pkg::OP_JL_RD: begin
				anc_ra = anc_addr(lvl_q, a_q);
				anc_rb = anc_addr(lvl_q, b_q);
			end
			lca_pkg::OP_PAR_RD: begin
				anc_ra = anc_addr('0, a_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NW'(1);
			built_q      <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_data;
				built_q      <= 1'b0;
			end
			if (op == lca_pkg::OP_SET && set_ok) begin
				built_q <= 1'b0;
			end
			if ((op == lca_pkg::OP_DEP_INIT && n_eff == '0)
				|| (op == lca_pkg::OP_DEP_WR && i_q == n_eff)) begin
				built_q <= 1'b1;
			end
			if (op == lca_pkg::OP_FINISH && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			lca_pkg::OP_BUILD: begin
				i_q <= '0;
			end
			lca_pkg::OP_QUERY: begin
				a_q <= req.node;
				b_q <= req.other_node;
				res_q.ancestor <= '0;
				res_q.status   <= q_bad ? lca_pkg::STAT_RANGE : lca_pkg::STAT_UNBUILT;
			end
			lca_pkg::OP_CLIP_WR, lca_pkg::OP_LVL_WR: begin
				if (i_q == n_eff) begin
					i_q   <= '0;
					lvl_q <= (op == lca_pkg::OP_CLIP_WR) ? LW'(1) : lvl_q + LW'(1);
				end else begin
					i_q <= i_q + NW'(1);
				end
			end
			lca_pkg::OP_DEP_INIT: begin
				i_q   <= NW'(1);
				u_q   <= NW'(1);
				d_q   <= '0;
				lvl_q <= LW'(LIFT_LEVELS - 1);
			end
			lca_pkg::OP_DEP_STEP: begin
				if (anc_qa != '0) begin
					u_q <= anc_qa;
					d_q <= d_q | (DW'(1) << lvl_q);
				end
				if (lvl_q != '0) begin
					lvl_q <= lvl_q - LW'(1);
				end
			end
			lca_pkg::OP_DEP_WR: begin
				i_q   <= i_q + NW'(1);
				u_q   <= i_q + NW'(1);
				d_q   <= '0;
				lvl_q <= LW'(LIFT_LEVELS - 1);
			end
			lca_pkg::OP_Q_SWAP: begin
				if (dep_qa > dep_qb) begin
					a_q    <= b_q;
					b_q    <= a_q;
					diff_q <= dep_qa - dep_qb;
				end else begin
					diff_q <= dep_qb - dep_qa;
				end
				lvl_q <= LW'(LIFT_LEVELS - 1);
			end
			lca_pkg::OP_UP_STEP: begin
				if (diff_q[lvl_q]) begin
					b_q <= anc_qa;
				end
				if (lvl_q != '0) begin
					lvl_q <= lvl_q - LW'(1);
				end
			end
			lca_pkg::OP_CHK: begin
				lvl_q          <= LW'(LIFT_LEVELS - 1);
				res_q.ancestor <= a_q;
				res_q.status   <= lca_pkg::STAT_OK;
			end
			lca_pkg::OP_JL_STEP: begin
				if (anc_qa != anc_qb) begin
					a_q <= anc_qa;
					b_q <= anc_qb;
				end
				if (lvl_q != '0) begin
					lvl_q <= lvl_q - LW'(1);
				end
			end
			lca_pkg::OP_PAR_GET: begin
				res_q.ancestor <= anc_qa;
				res_q.status   <= lca_pkg::STAT_OK;
			end
			lca_pkg::OP_FINISH: begin
				if (out_free) begin
					rsp_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	lca_ram #(
		.WIDTH (NW),
		.DEPTH (ANC_DEPTH)
	) u_anc_ram (
		.clk       (clk),
		.wr_en     (anc_we),
		.wr_addr   (anc_wa),
		.wr_data   (anc_wd),
		.rd_addr_a (anc_ra),
		.rd_addr_b (anc_rb),
		.rd_data_a (anc_qa),
		.rd_data_b (anc_qb)
	);

	lca_ram #(
		.WIDTH (DW),
		.DEPTH (DEP_DEPTH)
	) u_dep_ram (
		.clk       (clk),
		.wr_en     (dep_we),
		.wr_addr   (dep_wa),
		.wr_data   (dep_wd),
		.rd_addr_a (dep_ra),
		.rd_addr_b (dep_rb),
		.rd_data_a (dep_qa),
		.rd_data_b (dep_qb)
	);

endmodule

@@ hdl/tree_lowest_common_ancestor_unit.sv @@
// Channel   Signals                     Direction  Item
// req       req_valid/req_stall/req     in         cmd, node, parent_node, other_node
// rsp       rsp_valid/rsp_stall/rsp     out        ancestor, status (queries only)
// cfg       cfg_we/cfg_data             in         node_count
//
// A set is taken while idle, and the unit stays idle. A rejected query goes straight to the finish
// state. A build clips the parent links, fills each lifting level, then computes the depths,
// with at most one memory access per state. Reset sets node_count to 1 and marks the table
// not built; the memories keep their contents. A finished result sits in the rsp
// register while the next item is taken.
module tree_lowest_common_ancestor_unit #(
	parameter int MAX_NODES   = 1024,
	parameter int LIFT_LEVELS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  lca_pkg::req_item_t         req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output lca_pkg::rsp_item_t         rsp,
	input  logic                       cfg_we,
	input  logic [lca_pkg::NODE_W-1:0] cfg_data
);

	lca_pkg::dp_op_t     op;
	lca_pkg::dp_status_t st;

	lca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.cmd),
		.st        (st),
		.req_stall (req_stall),
		.op        (op)
	);

	lca_dp #(
		.MAX_NODES   (MAX_NODES),
		.LIFT_LEVELS (LIFT_LEVELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.rsp_stall (rsp_stall),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
